// ===== hdl/mrdr_pkg.sv =====
package mrdr_pkg;

	localparam int MRDR_MAX_STAGES = 12;
	localparam int MRDR_INDEX_BITS = 20;

	localparam int RADIX_BITS = 48;
	localparam int COUNT_BITS = 4;
	localparam int SIZE_BITS = 21;
	localparam int CODE_BITS = 4;
	localparam int CFG_DATA_BITS = 48;
	localparam int CFG_INDEX_BITS = 2;

	localparam logic [RADIX_BITS-1:0] RADICES_RESET = RADIX_BITS'(279620);
	localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(5);
	localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(1024);

	localparam logic [CODE_BITS-1:0] RADIX_ONE = CODE_BITS'(1);
	localparam logic [CODE_BITS-1:0] RADIX_TWO = CODE_BITS'(2);

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_STAGE_RADICES = 2'd0,
		REG_STAGE_COUNT = 2'd1,
		REG_TRANSFORM_SIZE = 2'd2
	} mrdr_reg_t;

	typedef struct packed {
		logic valid;
		logic oor;
	} mrdr_ctl_t;

endpackage

// ===== hdl/mrdr_digit_stage.sv =====
module mrdr_digit_stage
	import mrdr_pkg::*;
#(
	parameter int INDEX_BITS = MRDR_INDEX_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [CODE_BITS-1:0]  radix,
	input  mrdr_ctl_t             ctl_in,
	input  logic [INDEX_BITS-1:0] quot_in,
	input  logic [INDEX_BITS-1:0] acc_in,
	input  logic [INDEX_BITS-1:0] span_in,
	output mrdr_ctl_t             ctl_out,
	output logic [INDEX_BITS-1:0] quot_out,
	output logic [INDEX_BITS-1:0] acc_out,
	output logic [INDEX_BITS-1:0] span_out
);

	localparam int XW = INDEX_BITS + CODE_BITS;
	localparam int PW = 2 * INDEX_BITS;

	// Reciprocals floor(2^INDEX_BITS / r); the first estimate of a quotient is
	// at most one below the true value.
	logic [INDEX_BITS-1:0] recip [16];

	assign recip[0] = '0;
	assign recip[1] = '0;

	for (genvar g = 2; g < 16; g++) begin : g_recip
		localparam logic [INDEX_BITS:0] RV = {1'b1, {INDEX_BITS{1'b0}}} / (INDEX_BITS + 1)'(g);
		assign recip[g] = RV[INDEX_BITS-1:0];
	end

	logic [PW-1:0] prod;
	logic [XW-1:0] acc_mul;
	logic [XW-1:0] span_mul;

	mrdr_ctl_t ctl_s1;
	logic [INDEX_BITS-1:0] quot_s1;
	logic [INDEX_BITS-1:0] est_s1;
	logic [INDEX_BITS-1:0] acc_r_s1;
	logic [INDEX_BITS-1:0] span_s1;
	logic [CODE_BITS-1:0] radix_s1;

	assign prod = PW'(quot_in) * PW'(recip[radix]);
	assign acc_mul = XW'(acc_in) * XW'(radix);
	assign span_mul = XW'(span_in) * XW'(radix);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		quot_s1 <= quot_in;
		est_s1 <= (radix < RADIX_TWO) ? quot_in : prod[PW-1:INDEX_BITS];
		acc_r_s1 <= acc_mul[INDEX_BITS-1:0];
		span_s1 <= span_mul[INDEX_BITS-1:0];
		radix_s1 <= radix;
	end

	logic [XW-1:0] back_mul;
	logic [XW-1:0] rem_full;
	logic [XW-1:0] rem_fix;
	logic fix;
	logic [INDEX_BITS-1:0] quot_next;
	logic [CODE_BITS-1:0] digit;

	assign back_mul = XW'(est_s1) * XW'(radix_s1);
	assign rem_full = XW'(quot_s1) - back_mul;
	assign fix = rem_full >= XW'(radix_s1);
	assign rem_fix = fix ? (rem_full - XW'(radix_s1)) : rem_full;
	assign quot_next = fix ? (est_s1 + INDEX_BITS'(1)) : est_s1;
	assign digit = rem_fix[CODE_BITS-1:0];

	mrdr_ctl_t ctl_s2;
	logic [INDEX_BITS-1:0] quot_s2;
	logic [INDEX_BITS-1:0] acc_s2;
	logic [INDEX_BITS-1:0] span_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		quot_s2 <= quot_next;
		acc_s2 <= acc_r_s1 + INDEX_BITS'(digit);
		span_s2 <= span_s1;
	end

	assign ctl_out = ctl_s2;
	assign quot_out = quot_s2;
	assign acc_out = acc_s2;
	assign span_out = span_s2;

endmodule

// ===== hdl/mrdr_merge.sv =====
module mrdr_merge
	import mrdr_pkg::*;
#(
	parameter int INDEX_BITS = MRDR_INDEX_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mrdr_ctl_t             ctl_in,
	input  logic [INDEX_BITS-1:0] quot_in,
	input  logic [INDEX_BITS-1:0] acc_in,
	input  logic [INDEX_BITS-1:0] span_in,
	output logic                  done,
	output logic [INDEX_BITS-1:0] reversed_index,
	output logic                  out_of_range
);

	localparam int PW = 2 * INDEX_BITS;

	// The part of the index above the full span passes through unchanged.
	logic [PW-1:0] high_prod;

	mrdr_ctl_t ctl_s1;
	logic [INDEX_BITS-1:0] high_s1;
	logic [INDEX_BITS-1:0] acc_s1;

	assign high_prod = PW'(quot_in) * PW'(span_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		high_s1 <= high_prod[INDEX_BITS-1:0];
		acc_s1 <= acc_in;
	end

	logic done_s2;
	logic oor_s2;
	logic [INDEX_BITS-1:0] result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= ctl_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		oor_s2 <= ctl_s1.oor;
		result_s2 <= ctl_s1.oor ? '0 : (high_s1 + acc_s1);
	end

	assign done = done_s2;
	assign reversed_index = result_s2;
	assign out_of_range = oor_s2;

endmodule

// ===== hdl/mixed_radix_digit_reverse_index_core.sv =====
// Mixed-radix digit-reversal address generator for an FFT sample memory.
// A word is taken on a rising edge where start is high and busy is low; busy
// stays low, so one natural_index can be given in every cycle. Each word
// gives exactly one result: reversed_index and out_of_range are shown for one
// cycle together with done, and the receiver has no way to hold them off.
// The throughput is one word per cycle. Each radix stage takes two pipeline
// stages: a reciprocal multiply that estimates the quotient, then a one-step
// correction that yields the digit and folds it into the reversed index.
// The configuration port writes the stage radices, the stage count and the
// transform size on any edge with cfg_we high. The user must write it only
// while no word is in flight; the block itself does not enforce this. An
// index at or above the transform size returns zero with out_of_range set.
// Reset clears the pipeline valid bits, so no stray done appears, and restores
// the default configuration of five radix-4 stages over 1024 points.
module mixed_radix_digit_reverse_index_core
	import mrdr_pkg::*;
#(
	parameter int MAX_STAGES = MRDR_MAX_STAGES,
	parameter int INDEX_BITS = MRDR_INDEX_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [INDEX_BITS-1:0]     natural_index,
	output logic                      done,
	output logic [INDEX_BITS-1:0]     reversed_index,
	output logic                      out_of_range,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int CW = (INDEX_BITS > SIZE_BITS) ? INDEX_BITS : SIZE_BITS;
	localparam int CODES = RADIX_BITS / CODE_BITS;

	logic [RADIX_BITS-1:0] stage_radices_q;
	logic [COUNT_BITS-1:0] stage_count_q;
	logic [SIZE_BITS-1:0] transform_size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_radices_q <= RADICES_RESET;
			stage_count_q <= COUNT_RESET;
			transform_size_q <= SIZE_RESET;
		end else if (cfg_we) begin
			unique case (mrdr_reg_t'(cfg_index))
				REG_STAGE_RADICES: begin
					stage_radices_q <= cfg_data[RADIX_BITS-1:0];
				end
				REG_STAGE_COUNT: begin
					stage_count_q <= cfg_data[COUNT_BITS-1:0];
				end
				REG_TRANSFORM_SIZE: begin
					transform_size_q <= cfg_data[SIZE_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign busy = 1'b0;

	mrdr_ctl_t ctl_s0;
	logic [INDEX_BITS-1:0] idx_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s0 <= '0;
		end else begin
			ctl_s0.valid <= start;
			ctl_s0.oor <= CW'(natural_index) >= CW'(transform_size_q);
		end
	end

	always_ff @(posedge clk) begin
		idx_s0 <= natural_index;
	end

	mrdr_ctl_t ctl_c [MAX_STAGES+1];
	logic [INDEX_BITS-1:0] quot_c [MAX_STAGES+1];
	logic [INDEX_BITS-1:0] acc_c [MAX_STAGES+1];
	logic [INDEX_BITS-1:0] span_c [MAX_STAGES+1];

	assign ctl_c[0] = ctl_s0;
	assign quot_c[0] = idx_s0;
	assign acc_c[0] = '0;
	assign span_c[0] = INDEX_BITS'(1);

	for (genvar j = 0; j < MAX_STAGES; j++) begin : g_stage
		logic [CODE_BITS-1:0] code;
		logic active;
		logic [CODE_BITS-1:0] radix;

		if (j < CODES) begin : g_code
			assign code = stage_radices_q[CODE_BITS*j +: CODE_BITS];
		end else begin : g_none
			assign code = RADIX_ONE;
		end

		if (j == 0) begin : g_seed
			assign active = 1'b1;
		end else begin : g_later
			assign active = stage_count_q > COUNT_BITS'(j);
		end

		assign radix = (active && code >= RADIX_TWO) ? code : RADIX_ONE;

		mrdr_digit_stage #(
			.INDEX_BITS(INDEX_BITS)
		) u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.radix   (radix),
			.ctl_in  (ctl_c[j]),
			.quot_in (quot_c[j]),
			.acc_in  (acc_c[j]),
			.span_in (span_c[j]),
			.ctl_out (ctl_c[j+1]),
			.quot_out(quot_c[j+1]),
			.acc_out (acc_c[j+1]),
			.span_out(span_c[j+1])
		);
	end

	mrdr_merge #(
		.INDEX_BITS(INDEX_BITS)
	) u_merge (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl_in        (ctl_c[MAX_STAGES]),
		.quot_in       (quot_c[MAX_STAGES]),
		.acc_in        (acc_c[MAX_STAGES]),
		.span_in       (span_c[MAX_STAGES]),
		.done          (done),
		.reversed_index(reversed_index),
		.out_of_range  (out_of_range)
	);

endmodule

// ===== bench/mixed_radix_digit_reverse_index_core_tb.sv =====
`timescale 1ns / 1ps

module mixed_radix_digit_reverse_index_core_tb
	import mrdr_pkg::*;
();

	localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;
	localparam int FULL_RANGE = 1 << MRDR_INDEX_BITS;
	localparam int RANDOM_ITEMS = 1100;
	localparam int EXTREME_SETTINGS = 5;

	class reversal_scoreboard;
		typedef struct packed {
			logic [MRDR_INDEX_BITS-1:0] rev_index;
			logic oor;
		} word_t;

		logic [RADIX_BITS-1:0] radices;
		logic [COUNT_BITS-1:0] count;
		logic [SIZE_BITS-1:0] size;
		word_t expected_words[$];
		int errors;

		function new();
			radices = RADICES_RESET;
			count = COUNT_RESET;
			size = SIZE_RESET;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_INDEX_BITS-1:0] index, logic [CFG_DATA_BITS-1:0] data);
			case (index)
				REG_STAGE_RADICES: radices = data[RADIX_BITS-1:0];
				REG_STAGE_COUNT: count = data[COUNT_BITS-1:0];
				REG_TRANSFORM_SIZE: size = data[SIZE_BITS-1:0];
				default: ;
			endcase
		endfunction

		function longint unsigned stage_radix(int st);
			logic [CODE_BITS-1:0] code;
			if (st >= RADIX_BITS / CODE_BITS)
				return 1;
			code = radices[st*CODE_BITS +: CODE_BITS];
			return (code < RADIX_TWO) ? 1 : code;
		endfunction

		function logic [MRDR_INDEX_BITS-1:0] reverse_digits(logic [MRDR_INDEX_BITS-1:0] idx);
			longint unsigned k, span, r, m;
			int n;
			k = idx;
			n = (count > MRDR_MAX_STAGES) ? MRDR_MAX_STAGES : count;
			span = stage_radix(0);
			for (int st = 1; st < n; st++) begin
				r = stage_radix(st);
				if (r == 1)
					continue;
				m = span * r;
				k = (k * r) % m + (k / span) % r + m * (k / m);
				span = m;
			end
			return k[MRDR_INDEX_BITS-1:0];
		endfunction

		function void note_index(logic [MRDR_INDEX_BITS-1:0] idx);
			word_t w;
			if (idx >= size) begin
				w.rev_index = '0;
				w.oor = 1'b1;
			end else begin
				w.rev_index = reverse_digits(idx);
				w.oor = 1'b0;
			end
			expected_words.insert(expected_words.size(), w);
		endfunction

		function void check_result(logic [MRDR_INDEX_BITS-1:0] got_index, logic got_oor);
			word_t w;
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual index %h flag %b",
					$time, got_index, got_oor);
				errors++;
				return;
			end
			w = expected_words.pop_front();
			if (w.rev_index !== got_index) begin
				$display("%0t: reversed_index expected %h actual %h", $time, w.rev_index,
					got_index);
				errors++;
			end
			if (w.oor !== got_oor) begin
				$display("%0t: out_of_range expected %b actual %b", $time, w.oor, got_oor);
				errors++;
			end
		endfunction

		function int pending();
			return expected_words.size();
		endfunction

		function void report_leftover();
			foreach (expected_words[i]) begin
				$display("%0t: missing word, expected index %h flag %b actual none", $time,
					expected_words[i].rev_index, expected_words[i].oor);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [MRDR_INDEX_BITS-1:0] natural_index = '0;
	logic done;
	logic [MRDR_INDEX_BITS-1:0] reversed_index;
	logic out_of_range;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = REG_STAGE_RADICES;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	reversal_scoreboard sb = new();

	mixed_radix_digit_reverse_index_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.natural_index(natural_index),
		.done(done),
		.reversed_index(reversed_index),
		.out_of_range(out_of_range),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(reversed_index, out_of_range);
	end

	function automatic logic [CFG_DATA_BITS-1:0] random_data();
		return CFG_DATA_BITS'({$urandom, $urandom});
	endfunction

	function automatic logic [MRDR_INDEX_BITS-1:0] pick_index();
		longint unsigned lim;
		lim = (sb.size > FULL_RANGE) ? FULL_RANGE : sb.size;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5, 6: begin
				if (lim == 0)
					return MRDR_INDEX_BITS'($urandom);
				return MRDR_INDEX_BITS'($urandom_range(0, lim - 1));
			end
			7: return MRDR_INDEX_BITS'(sb.size - $urandom_range(0, 1));
			default: return MRDR_INDEX_BITS'($urandom);
		endcase
	endfunction

	task automatic send_index(logic [MRDR_INDEX_BITS-1:0] value);
		@(negedge clk);
		start <= 1'b1;
		natural_index <= value;
		do
			@(posedge clk);
		while (busy);
		sb.note_index(value);
	endtask

	task automatic send_random(int n);
		int sent, burst, gap;
		sent = 0;
		while (sent < n) begin
			burst = $urandom_range(1, 24);
			for (int i = 0; i < burst && sent < n; i++) begin
				send_index(pick_index());
				sent++;
			end
			gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				start <= 1'b0;
				natural_index <= MRDR_INDEX_BITS'($urandom);
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (sb.pending() > 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_BITS-1:0] index, logic [CFG_DATA_BITS-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
		sb.write_reg(index, data);
	endtask

	// Register values are padded with random bits above their width.
	task automatic apply_config(logic [RADIX_BITS-1:0] radices, logic [COUNT_BITS-1:0] count,
			logic [SIZE_BITS-1:0] size);
		logic [CFG_DATA_BITS-1:0] pad;
		pad = random_data();
		write_reg(REG_STAGE_RADICES, radices);
		write_reg(REG_STAGE_COUNT, {pad[CFG_DATA_BITS-1:COUNT_BITS], count});
		write_reg(REG_TRANSFORM_SIZE, {pad[CFG_DATA_BITS-1:SIZE_BITS], size});
		if ($urandom_range(0, 3) == 0)
			write_reg(REG_UNUSED, random_data());
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_data <= random_data();
	endtask

	task automatic extreme_config(int sel);
		case (sel)
			0: apply_config({RADIX_BITS{1'b1}}, 4'd15, {SIZE_BITS{1'b1}});
			1: apply_config('0, 4'd0, '0);
			2: apply_config(48'h00_4444_4444_44, 4'd10, SIZE_BITS'(FULL_RANGE));
			3: apply_config(48'h2222_2222_2222, 4'd12, 21'd4096);
			default: apply_config(48'h1111_1111_1111, 4'd12, 21'd1);
		endcase
	endtask

	task automatic random_config();
		int good_codes[6] = '{2, 3, 4, 5, 7, 8};
		logic [RADIX_BITS-1:0] radices;
		logic [CODE_BITS-1:0] code;
		longint unsigned product, r;
		int n, count, size;
		radices = random_data();
		n = $urandom_range(1, MRDR_MAX_STAGES);
		product = 1;
		for (int st = 0; st < n; st++) begin
			if ($urandom_range(0, 9) != 0)
				code = CODE_BITS'(good_codes[$urandom_range(0, 5)]);
			else
				code = CODE_BITS'($urandom_range(0, 15));
			r = (code < RADIX_TWO) ? 1 : code;
			if (product * r > FULL_RANGE) begin
				code = RADIX_ONE;
				r = 1;
			end
			radices[st*CODE_BITS +: CODE_BITS] = code;
			product *= r;
		end
		count = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : n;
		size = ($urandom_range(0, 7) == 0) ? $urandom_range(0, (1 << SIZE_BITS) - 1) :
			int'(product);
		apply_config(radices, COUNT_BITS'(count), SIZE_BITS'(size));
	endtask

	initial begin
		int total, items, phase;
		logic [MRDR_INDEX_BITS-1:0] defaults_list[10];

		defaults_list = '{0, 1, 2, 3, 4, 1023, 1024, 20'hFFFFF, 20'h55555, 20'hAAAAA};

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (defaults_list[i])
			send_index(defaults_list[i]);
		drain();

		apply_config(48'h8754_32, 4'd6, 21'd6720);
		send_index(0);
		send_index(1);
		send_index(6719);
		send_index(6720);
		send_index(3000);
		drain();

		// Seed code zero, a radix code of one, then the codes 6, 14, 9 and 15.
		apply_config(48'hF9E6_10, 4'd6, 21'd11340);
		send_index(0);
		send_index(11339);
		send_index(5000);
		drain();

		apply_config(48'h4444, 4'd4, 21'd0);
		send_index(0);
		send_index(5);
		drain();

		total = 0;
		phase = 0;
		while (total < RANDOM_ITEMS) begin
			if (phase < EXTREME_SETTINGS)
				extreme_config(phase);
			else
				random_config();
			items = $urandom_range(40, 70);
			send_random(items);
			drain();
			total += items;
			phase++;
		end

		repeat (2 * MRDR_MAX_STAGES + 10) @(posedge clk);
		sb.report_leftover();
		if (sb.errors == 0)
			$display("PASS mixed_radix_digit_reverse_index_core");
		else
			$display("FAIL mixed_radix_digit_reverse_index_core");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAIL mixed_radix_digit_reverse_index_core");
		$finish;
	end

endmodule
